FILE: hdl/kcl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants for the keypad code configuration block.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int CODE_DIGITS_DEF = 4;

    localparam int SLOT_COUNT = 5;
    localparam int SLOT_W     = 3;
    localparam int COUNT_W    = 3;
    localparam int VALUE_W    = 14;
    localparam int CODE_W     = 16;
    localparam int STATUS_W   = 4;
    localparam int KEY_W      = 8;

    localparam logic [CODE_W-1:0] CODE_DISABLED = 16'hFFFF;
    localparam logic [CODE_W-1:0] MASTER_RESET  = 16'h0000;

    localparam logic [KEY_W-1:0] KEY_0       = 8'h30;
    localparam logic [KEY_W-1:0] KEY_1       = 8'h31;
    localparam logic [KEY_W-1:0] KEY_4       = 8'h34;
    localparam logic [KEY_W-1:0] KEY_9       = 8'h39;
    localparam logic [KEY_W-1:0] KEY_MASTER  = 8'h61;  // 'a'
    localparam logic [KEY_W-1:0] KEY_DISABLE = 8'h64;  // 'd'

    localparam logic ACT_BEGIN = 1'b0;

    localparam logic [SLOT_W-1:0] SLOT_MASTER = 3'd0;

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED      = 4'd0,
        ST_ENTER_MASTER = 4'd1,
        ST_DENIED       = 4'd2,
        ST_MENU         = 4'd3,
        ST_BAD          = 4'd4,
        ST_ENTER_CODE   = 4'd5,
        ST_NO_DISABLE   = 4'd6,
        ST_STORED       = 4'd7,
        ST_DIGIT        = 4'd8
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_MASTER = 4'b0010,
        PH_MENU   = 4'b0100,
        PH_CODE   = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [COUNT_W-1:0]  count;
        logic [VALUE_W-1:0]  value;
        logic [SLOT_W-1:0]   slot;
    } sess_state_t;

    typedef struct packed {
        logic               valid;
        logic [SLOT_W-1:0]  slot;
        logic [CODE_W-1:0]  code;
    } slot_write_t;

endpackage : kcl_pkg
`default_nettype wire

FILE: hdl/kcl_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_store
// Five code slots in flops; slot 0 (master) is read out for the compare.
// ----------------------------------------------------------------------------
module kcl_store (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire kcl_pkg::slot_write_t      wr,
    output logic [kcl_pkg::CODE_W-1:0]     master_code
);
    import kcl_pkg::*;

    logic [CODE_W-1:0] slot_reg [SLOT_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_reg[i] <= (i == 0) ? MASTER_RESET : CODE_DISABLED;
            end
        end else if (wr.valid) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (wr.slot == SLOT_W'(i)) begin
                    slot_reg[i] <= wr.code;
                end
            end
        end
    end

    assign master_code = slot_reg[0];

endmodule : kcl_store
`default_nettype wire

FILE: hdl/kcl_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_step
// Next-state and result logic for one beat of the code configuration FSM.
// ----------------------------------------------------------------------------
module kcl_step #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input  wire logic                         action,
    input  wire logic [kcl_pkg::KEY_W-1:0]    key,
    input  wire kcl_pkg::sess_state_t         cur,
    input  wire logic [kcl_pkg::CODE_W-1:0]   master_code,
    output kcl_pkg::sess_state_t              nxt,
    output kcl_pkg::status_t                  status,
    output kcl_pkg::slot_write_t              wr
);
    import kcl_pkg::*;

    logic                 is_digit;
    logic [VALUE_W+3:0]   acc;
    logic [VALUE_W-1:0]   val_new;
    logic [COUNT_W-1:0]   cnt_new;
    logic                 entry_done;
    logic                 menu_pick;
    logic [SLOT_W-1:0]    code_slot;

    assign is_digit   = (key >= KEY_0) && (key <= KEY_9);
    // ASCII digits carry their value in the low nibble
    assign acc        = ({4'd0, cur.value} * (VALUE_W+4)'(10)) + (VALUE_W+4)'(key[3:0]);
    assign val_new    = acc[VALUE_W-1:0];
    assign cnt_new    = cur.count + COUNT_W'(1);
    assign entry_done = (cnt_new >= COUNT_W'(CODE_DIGITS));
    assign menu_pick  = (key == KEY_MASTER) || ((key >= KEY_1) && (key <= KEY_4));
    assign code_slot  = (cur.slot < SLOT_W'(SLOT_COUNT)) ? cur.slot : SLOT_MASTER;

    always_comb begin
        nxt      = cur;
        status   = ST_IGNORED;
        wr.valid = 1'b0;
        wr.slot  = '0;
        wr.code  = '0;

        if (action == ACT_BEGIN) begin
            nxt.phase = PH_MASTER;
            nxt.count = '0;
            nxt.value = '0;
            status    = ST_ENTER_MASTER;
        end else begin
            unique case (cur.phase)
                PH_MASTER: begin
                    if (!is_digit) begin
                        nxt.phase = PH_IDLE;
                        nxt.count = '0;
                        nxt.value = '0;
                        status    = ST_DENIED;
                    end else if (entry_done) begin
                        nxt.count = '0;
                        nxt.value = '0;
                        if ({2'b00, val_new} == master_code) begin
                            nxt.phase = PH_MENU;
                            status    = ST_MENU;
                        end else begin
                            nxt.phase = PH_IDLE;
                            status    = ST_DENIED;
                        end
                    end else begin
                        nxt.count = cnt_new;
                        nxt.value = val_new;
                        status    = ST_DIGIT;
                    end
                end
                PH_MENU: begin
                    if (menu_pick) begin
                        nxt.slot  = (key == KEY_MASTER) ? SLOT_MASTER : key[SLOT_W-1:0];
                        nxt.phase = PH_CODE;
                        nxt.count = '0;
                        nxt.value = '0;
                        status    = ST_ENTER_CODE;
                    end else begin
                        status = ST_BAD;
                    end
                end
                PH_CODE: begin
                    if (key == KEY_DISABLE) begin
                        if (code_slot == SLOT_MASTER) begin
                            nxt.count = '0;
                            nxt.value = '0;
                            status    = ST_NO_DISABLE;
                        end else begin
                            wr.valid = 1'b1;
                            wr.slot  = code_slot;
                            wr.code  = CODE_DISABLED;
                        end
                    end else if (is_digit) begin
                        if (entry_done) begin
                            wr.valid = 1'b1;
                            wr.slot  = code_slot;
                            wr.code  = {2'b00, val_new};
                        end else begin
                            nxt.count = cnt_new;
                            nxt.value = val_new;
                            status    = ST_DIGIT;
                        end
                    end else begin
                        nxt.count = '0;
                        nxt.value = '0;
                        status    = ST_BAD;
                    end
                    if (wr.valid) begin
                        nxt.phase = PH_IDLE;
                        nxt.count = '0;
                        nxt.value = '0;
                        status    = ST_STORED;
                    end
                end
                default: begin
                    // idle: key presses are ignored
                end
            endcase
        end
    end

endmodule : kcl_step
`default_nettype wire

FILE: hdl/keypad_code_config_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_code_config_fsm
// Keypad-driven configuration of a five-slot code lock.
//
// Input channel (s_): one beat per keypad event. s_action = 0 starts a
// session (master code prompt); s_action = 1 carries an ASCII key in s_key.
// Result channel (m_): exactly one beat per input beat, in order. m_status
// gives the prompt/outcome; when m_write_valid is high, m_write_slot and
// m_write_code name the slot just updated so an external non-volatile
// writer can mirror it (0xFFFF marks a disabled slot).
//
// Latency: result is valid the cycle after the input beat is accepted.
// Throughput: one beat per cycle unless stalled. All decoding, the digit accumulate
// (x10 + digit) and the master compare settle in one combinational pass
// between the session registers and the result register.
// Stall: the result register holds while m_ready is low; a new beat is
// still taken in the same cycle the held result is drained, so s_ready
// only drops while a result waits and m_ready is low.
// Reset (aresetn low, synchronous): session idle, partial entry cleared,
// master slot = 0x0000, slots 1..4 disabled, no result pending.
// ----------------------------------------------------------------------------
module keypad_code_config_fsm #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_action,
    input  wire logic [kcl_pkg::KEY_W-1:0]      s_key,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [kcl_pkg::STATUS_W-1:0]        m_status,
    output logic                                m_write_valid,
    output logic [kcl_pkg::SLOT_W-1:0]          m_write_slot,
    output logic [kcl_pkg::CODE_W-1:0]          m_write_code
);
    import kcl_pkg::*;

    // session state
    sess_state_t        sess_reg;
    sess_state_t        sess_next;

    // result register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                wvalid_reg;
    logic [SLOT_W-1:0]   wslot_reg;
    logic [CODE_W-1:0]   wcode_reg;

    status_t             step_status;
    slot_write_t         step_wr;
    slot_write_t         store_wr;
    logic [CODE_W-1:0]   master_code;
    logic                s_beat;

    // Accept whenever the result slot is free or being drained this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;

    kcl_step #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_step (
        .action      (s_action),
        .key         (s_key),
        .cur         (sess_reg),
        .master_code (master_code),
        .nxt         (sess_next),
        .status      (step_status),
        .wr          (step_wr)
    );

    // Slot write only commits on an accepted beat.
    always_comb begin
        store_wr       = step_wr;
        store_wr.valid = step_wr.valid && s_beat;
    end

    kcl_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr          (store_wr),
        .master_code (master_code)
    );

    // Session registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sess_reg.phase <= PH_IDLE;
            sess_reg.count <= '0;
            sess_reg.value <= '0;
            sess_reg.slot  <= SLOT_MASTER;
        end else if (s_beat) begin
            sess_reg <= sess_next;
        end
    end

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted beat
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            status_reg <= step_status;
            wvalid_reg <= step_wr.valid;
            wslot_reg  <= step_wr.slot;
            wcode_reg  <= step_wr.code;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_write_valid = wvalid_reg;
    assign m_write_slot  = wslot_reg;
    assign m_write_code  = wcode_reg;

endmodule : keypad_code_config_fsm
`default_nettype wire
